FILE: rtl/pvd_pkg.sv
package pvd_pkg;

    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 64;
    localparam int LEFT_W  = 5;

    // bytes still to come after a first byte, per prefix class
    localparam logic [LEFT_W-1:0] LEFT_NONE = 5'd0;
    localparam logic [LEFT_W-1:0] LEFT_ONE  = 5'd1;
    localparam logic [LEFT_W-1:0] LEFT_TWO  = 5'd2;
    localparam logic [LEFT_W-1:0] LEFT_THR  = 5'd3;
    localparam logic [LEFT_W-1:0] LEFT_FOUR = 5'd4;
    localparam logic [LEFT_W-1:0] LEFT_FIVE = 5'd5;
    localparam logic [LEFT_W-1:0] LEFT_FULL = 5'd8;
    localparam logic [LEFT_W-1:0] LEFT_RSVD = 5'd16;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              signed_mode;
    } t_in;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               reserved_prefix;
    } t_out;

endpackage

FILE: rtl/pvd_in_stage.sv
module pvd_in_stage
    import pvd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_in  i_in,
    output logic o_in_stall,
    input  logic i_go,
    output logic o_valid,
    output t_in  o_beat
);

    logic r_valid;
    logic n_valid;
    t_in  r_beat;
    logic w_accept;

    assign o_in_stall = r_valid && !i_go;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_go) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_beat <= i_in;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

FILE: rtl/pvd_core.sv
module pvd_core
    import pvd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_beat,
    input  logic i_out_free,
    output logic o_go,
    output logic o_res_valid,
    output t_out o_res
);

    logic [LEFT_W-1:0]  r_bytes_left;
    logic [LEFT_W-1:0]  n_bytes_left;
    logic [VALUE_W-1:0] r_acc;
    logic [VALUE_W-1:0] n_acc;
    logic               r_rsvd;
    logic               n_rsvd;

    logic [VALUE_W-1:0] f_data;
    logic [LEFT_W-1:0]  f_left;
    logic               f_rsvd;
    logic [VALUE_W-1:0] w_shifted;
    logic               w_first;
    logic               w_res;
    logic [BYTE_W-1:0]  w_b;
    logic               w_sx;

    assign w_b     = i_beat.in_byte;
    assign w_sx    = i_beat.signed_mode;
    assign w_first = (r_bytes_left == LEFT_NONE);

    // first-byte decode: leading ones set length; under 0xFC the rest is data
    always_comb begin
        f_data = '0;
        f_left = LEFT_NONE;
        f_rsvd = 1'b0;
        case (w_b) inside
            8'b0???????: begin
                f_data = {{57{w_sx & w_b[6]}}, w_b[6:0]};
                f_left = LEFT_NONE;
            end
            8'b10??????: begin
                f_data = {{58{w_sx & w_b[5]}}, w_b[5:0]};
                f_left = LEFT_ONE;
            end
            8'b110?????: begin
                f_data = {{59{w_sx & w_b[4]}}, w_b[4:0]};
                f_left = LEFT_TWO;
            end
            8'b1110????: begin
                f_data = {{60{w_sx & w_b[3]}}, w_b[3:0]};
                f_left = LEFT_THR;
            end
            8'b11110???: begin
                f_data = {{61{w_sx & w_b[2]}}, w_b[2:0]};
                f_left = LEFT_FOUR;
            end
            8'b111110??: begin
                f_data = {{62{w_sx & w_b[1]}}, w_b[1:0]};
                f_left = LEFT_FIVE;
            end
            8'b1111110?: begin
                f_left = LEFT_FULL;
            end
            default: begin
                f_left = LEFT_RSVD;
                f_rsvd = 1'b1;
            end
        endcase
    end

    assign w_shifted = {r_acc[VALUE_W-BYTE_W-1:0], w_b};

    // a result leaves on a one-byte value or on the last following byte
    assign w_res = w_first ? (f_left == LEFT_NONE) : (r_bytes_left == LEFT_ONE);
    assign o_go  = i_valid && (!w_res || i_out_free);

    always_comb begin
        n_bytes_left = r_bytes_left;
        n_acc        = r_acc;
        n_rsvd       = r_rsvd;
        if (o_go) begin
            if (w_first) begin
                n_bytes_left = f_left;
                n_acc        = f_data;
                n_rsvd       = f_rsvd;
            end else begin
                n_bytes_left = r_bytes_left - LEFT_ONE;
                n_acc        = w_shifted;
                if (r_bytes_left == LEFT_ONE) begin
                    n_rsvd = 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_res_valid = o_go && w_res;
        if (w_first) begin
            o_res.value           = f_data;
            o_res.reserved_prefix = 1'b0;
        end else begin
            o_res.value           = r_rsvd ? '0 : w_shifted;
            o_res.reserved_prefix = r_rsvd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left <= LEFT_NONE;
            r_acc        <= '0;
            r_rsvd       <= 1'b0;
        end else begin
            r_bytes_left <= n_bytes_left;
            r_acc        <= n_acc;
            r_rsvd       <= n_rsvd;
        end
    end

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bytes_left <= LEFT_RSVD)
        else $error("byte count beyond longest prefix");

    a_rsvd_mid_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsvd |-> (r_bytes_left != LEFT_NONE))
        else $error("reserved flag left over after value end");

    a_rsvd_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.reserved_prefix) |-> (o_res.value == '0))
        else $error("reserved result carries data");

    a_res_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_out_free)
        else $error("result issued with output register full");

endmodule

FILE: rtl/pvd_out_stage.sv
module pvd_out_stage
    import pvd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  t_out i_res,
    output logic o_free,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    logic r_valid;
    logic n_valid;
    t_out r_res;

    assign o_free = !r_valid || !i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_res;

endmodule

FILE: rtl/prefix_varint_decoder_unit.sv
// Prefix-length varint decoder. One stream byte is taken per cycle, sustained,
// with no gaps between values, unless the output stalls; a byte goes through an
// input register and the decode/accumulate step, and a value enters the output
// register with its last byte. The first byte's leading ones set the length
// (1 to 6 bytes, 9 bytes after 0xFC/0xFD, 17 bytes after reserved 0xFE/0xFF,
// which yield zero with reserved_prefix set). signed_mode counts on first bytes
// only. Output stall holds the result register and backs up into input.
module prefix_varint_decoder_unit
    import pvd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out
);

    logic w_go;
    logic w_stage_valid;
    t_in  w_stage_beat;
    logic w_out_free;
    logic w_res_valid;
    t_out w_res;

    pvd_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_go       (w_go),
        .o_valid    (w_stage_valid),
        .o_beat     (w_stage_beat)
    );

    pvd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_stage_valid),
        .i_beat      (w_stage_beat),
        .i_out_free  (w_out_free),
        .o_go        (w_go),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    pvd_out_stage u_out_stage (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_res_valid),
        .i_res       (w_res),
        .o_free      (w_out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule
